/* rtl/core/mdhgj_pkg.sv */
// Package for the modified-DH geometric Jacobian block.
// Holds fixed-point constants, the CORDIC arctangent table and the shared helpers.
package mdhgj_pkg;

	localparam int MAX_JOINTS   = 6;
	localparam int CORDIC_STEPS = 16;
	localparam int JW           = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int SW           = $clog2(CORDIC_STEPS + 1);

	localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
	localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef logic signed [31:0] word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CORDIC, ST_JOINT, ST_RMUL, ST_PMUL, ST_STORE, ST_COL_RD,
		ST_COL_WAIT, ST_COL_MUL, ST_COL_OUT
	} state_t;

	function automatic logic signed [33:0] arc_at(input logic [4:0] i);
		logic signed [33:0] r;
		begin
			case (i)
				5'd0: r = 34'sd843314856;  5'd1: r = 34'sd497837829;
				5'd2: r = 34'sd263043836;  5'd3: r = 34'sd133525158;
				5'd4: r = 34'sd67021686;   5'd5: r = 34'sd33543515;
				5'd6: r = 34'sd16775850;   5'd7: r = 34'sd8388437;
				5'd8: r = 34'sd4194282;    5'd9: r = 34'sd2097149;
				5'd10: r = 34'sd1048575;   5'd11: r = 34'sd524287;
				5'd12: r = 34'sd262143;    5'd13: r = 34'sd131071;
				5'd14: r = 34'sd65535;     5'd15: r = 34'sd32767;
				5'd16: r = 34'sd16383;     5'd17: r = 34'sd8191;
				5'd18: r = 34'sd4095;      5'd19: r = 34'sd2047;
				5'd20: r = 34'sd1023;      5'd21: r = 34'sd511;
				5'd22: r = 34'sd255;       5'd23: r = 34'sd127;
				5'd24: r = 34'sd63;        5'd25: r = 34'sd31;
				5'd26: r = 34'sd15;        5'd27: r = 34'sd7;
				5'd28: r = 34'sd3;         5'd29: r = 34'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// Q2.30 product, rounded half up; operands are 34-bit signed.
	function automatic logic signed [35:0] mulq(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		begin
			p = a * b;
			return 36'(((p >>> 29) + 68'sd1) >>> 1);
		end
	endfunction

	function automatic word_t sat32(input logic signed [37:0] v);
		begin
			if (v > 38'sd2147483647) return 32'h7fffffff;
			else if (v < -38'sd2147483648) return 32'h80000000;
			else return v[31:0];
		end
	endfunction

endpackage

/* rtl/core/mdhgj_cordic.sv */
// Iterative CORDIC sine/cosine unit, one rotation step per cycle.
// Depends on mdhgj_pkg.
module mdhgj_cordic (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [15:0]      angle,
	output logic                    done,
	output logic signed [33:0]      sin_o,
	output logic signed [33:0]      cos_o
);
	import mdhgj_pkg::*;

	logic signed [35:0] x_q, y_q, z_q;
	logic               flip_q, busy_q;
	logic [SW-1:0]      step_q;
	logic signed [35:0] za, xn, yn, xf, yf;

	always_comb begin
		za = 36'(angle) <<< 17;
		xn = (z_q >= 0) ? x_q - (y_q >>> step_q) : x_q + (y_q >>> step_q);
		yn = (z_q >= 0) ? y_q + (x_q >>> step_q) : y_q - (x_q >>> step_q);
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == SW'(CORDIC_STEPS)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= 36'(CORDIC_GAIN);
			y_q <= '0;
			if (za > 36'(Q30_HALF_PI)) begin
				z_q <= za - 36'(Q30_PI); flip_q <= 1'b1;
			end else if (za < -36'(Q30_HALF_PI)) begin
				z_q <= za + 36'(Q30_PI); flip_q <= 1'b1;
			end else begin
				z_q <= za; flip_q <= 1'b0;
			end
		end else if (busy_q && step_q != SW'(CORDIC_STEPS)) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= (z_q >= 0) ? z_q - 36'(arc_at(5'(step_q))) : z_q + 36'(arc_at(5'(step_q)));
		end
		if (busy_q && step_q == SW'(CORDIC_STEPS)) begin
			cos_o <= (xf > 36'(Q30_ONE)) ? Q30_ONE : (xf < -36'(Q30_ONE)) ? -Q30_ONE : xf[33:0];
			sin_o <= (yf > 36'(Q30_ONE)) ? Q30_ONE : (yf < -36'(Q30_ONE)) ? -Q30_ONE : yf[33:0];
		end
	end

endmodule

/* rtl/core/mdhgj_store.sv */
// Per-joint axis and origin memory, six words per entry, registered read.
// Depends on mdhgj_pkg.
module mdhgj_store (
	input  logic                  clk,
	input  logic                  we,
	input  logic [mdhgj_pkg::JW-1:0] waddr,
	input  logic [191:0]          wdata,
	input  logic [mdhgj_pkg::JW-1:0] raddr,
	output logic [191:0]          rdata
);
	import mdhgj_pkg::*;

	logic [191:0] mem [MAX_JOINTS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/mdh_geometric_jacobian.sv */
// Top level of the modified-DH geometric Jacobian block.
// Depends on mdhgj_pkg, mdhgj_cordic and mdhgj_store.
//
// Usage: one input item per joint (angle, twist, length, offset, last flag).
// Each item runs two CORDIC passes on one shared unit, builds the joint
// transform, then multiplies into the running frame one row per cycle (the
// rotation rows first, then the origin rows) and writes the new z axis and
// origin into the joint memory. Intermediate joints give no result. On the
// last joint (flag set or joint MAX_JOINTS-1) the block reads the joint
// memory back one entry at a time and emits one column item per joint. A
// result register holds the column while ready is low; the sequencer stalls
// on it. In_ready is high only in idle. After the last column the frame
// returns to identity and zero origin and the joint count to zero.
// Reset (arst_n low) clears the sequencer, frame and count; the joint memory
// is not cleared since only entries of the current chain are read.
module mdh_geometric_jacobian (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] joint_angle,
	input  logic signed [15:0] link_twist,
	input  logic signed [31:0] link_length,
	input  logic signed [31:0] link_offset,
	input  logic               last_joint,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         column_index,
	output logic signed [31:0] lin_x,
	output logic signed [31:0] lin_y,
	output logic signed [31:0] lin_z,
	output logic signed [31:0] ang_x,
	output logic signed [31:0] ang_y,
	output logic signed [31:0] ang_z,
	output logic               last_column
);
	import mdhgj_pkg::*;

	state_t state_q, state_d;

	// Hold the item.
	logic signed [15:0] tw_q;
	logic signed [31:0] len_q, off_q;
	logic               lastf_q, twist_pass_q;
	logic [JW-1:0]      k_q, col_q;
	logic [1:0]         row_q;
	logic [3:0]         rb0, rb1, rb2;

	logic               cstart, cdone;
	logic signed [15:0] cangle;
	logic signed [33:0] csin, ccos, st_q, ct_q, sa_q, ca_q;

	word_t rot_q [9];
	word_t org_q [3];
	word_t nr_q [9];
	word_t np_q [3];
	logic signed [33:0] rj_q [9];
	word_t pj_q [3];

	logic               mem_we;
	logic [191:0]       mem_rd, mem_wd;
	logic [JW-1:0]      mem_ra;

	logic signed [35:0] lx_s1 [6];
	word_t              ax_s1 [3];

	// Sequencer.
	always_comb begin
		state_d = state_q;
		cstart  = 1'b0;
		cangle  = tw_q;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				state_d = ST_CORDIC;
				cstart  = 1'b1;
				cangle  = joint_angle;
			end
			ST_CORDIC: if (cdone) begin
				if (!twist_pass_q) cstart = 1'b1;
				else state_d = ST_JOINT;
			end
			ST_JOINT: state_d = ST_RMUL;
			ST_RMUL:  if (row_q == 2'd2) state_d = ST_PMUL;
			ST_PMUL:  if (row_q == 2'd2) state_d = ST_STORE;
			ST_STORE: state_d = (lastf_q || 32'(k_q) + 1 >= MAX_JOINTS) ? ST_COL_RD : ST_IDLE;
			ST_COL_RD: state_d = ST_COL_WAIT;
			ST_COL_WAIT: state_d = ST_COL_MUL;
			ST_COL_MUL: state_d = ST_COL_OUT;
			ST_COL_OUT: if (!out_valid || out_ready)
				state_d = (col_q == k_q) ? ST_IDLE : ST_COL_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign mem_we   = (state_q == ST_STORE);
	assign mem_ra   = col_q;
	assign mem_wd   = {nr_q[2], nr_q[5], nr_q[8], np_q[0], np_q[1], np_q[2]};

	// Flat indexes of the three entries of the current frame row.
	assign rb0 = 4'(row_q) * 4'd3;
	assign rb1 = rb0 + 4'd1;
	assign rb2 = rb0 + 4'd2;

	mdhgj_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart), .angle(cangle),
		.done(cdone), .sin_o(csin), .cos_o(ccos)
	);

	mdhgj_store u_store (
		.clk(clk), .we(mem_we), .waddr(k_q), .wdata(mem_wd),
		.raddr(mem_ra), .rdata(mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			twist_pass_q <= 1'b0;
			k_q          <= '0;
			col_q        <= '0;
			row_q        <= '0;
			out_valid    <= 1'b0;
			for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? 32'h40000000 : '0;
			for (int i = 0; i < 3; i++) org_q[i] <= '0;
		end else begin
			state_q <= state_d;
			// Raise valid on a new column, drop it once the column is taken.
			if (state_q == ST_COL_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: twist_pass_q <= 1'b0;
				ST_CORDIC: if (cdone) twist_pass_q <= 1'b1;
				ST_JOINT: row_q <= '0;
				ST_RMUL, ST_PMUL: row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 1'b1;
				ST_STORE: begin
					for (int i = 0; i < 9; i++) rot_q[i] <= nr_q[i];
					for (int i = 0; i < 3; i++) org_q[i] <= np_q[i];
					col_q <= '0;
					if (!(lastf_q || 32'(k_q) + 1 >= MAX_JOINTS)) k_q <= k_q + 1'b1;
				end
				ST_COL_OUT: if (!out_valid || out_ready) begin
					if (col_q == k_q) begin
						k_q <= '0;
						for (int i = 0; i < 9; i++)
							rot_q[i] <= (i % 4 == 0) ? 32'h40000000 : '0;
						for (int i = 0; i < 3; i++) org_q[i] <= '0;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			tw_q <= link_twist; len_q <= link_length;
			off_q <= link_offset; lastf_q <= last_joint;
		end
		if (state_q == ST_CORDIC && cdone) begin
			if (!twist_pass_q) begin st_q <= csin; ct_q <= ccos; end
			else begin sa_q <= csin; ca_q <= ccos; end
		end
		if (state_q == ST_JOINT) begin
			rj_q[0] <= ct_q;  rj_q[1] <= -st_q; rj_q[2] <= '0;
			rj_q[3] <= 34'(mulq(st_q, ca_q)); rj_q[4] <= 34'(mulq(ct_q, ca_q));
			rj_q[5] <= -sa_q;
			rj_q[6] <= 34'(mulq(st_q, sa_q)); rj_q[7] <= 34'(mulq(ct_q, sa_q));
			rj_q[8] <= ca_q;
			pj_q[0] <= len_q;
			pj_q[1] <= sat32(-38'(mulq(sa_q, 34'(off_q))));
			pj_q[2] <= sat32(38'(mulq(ca_q, 34'(off_q))));
		end
		if (state_q == ST_RMUL)
			for (int c = 0; c < 3; c++)
				nr_q[rb0 + 4'(c)] <= sat32(38'(mulq(34'(rot_q[rb0]), rj_q[c]))
					+ 38'(mulq(34'(rot_q[rb1]), rj_q[3+c]))
					+ 38'(mulq(34'(rot_q[rb2]), rj_q[6+c])));
		if (state_q == ST_PMUL)
			np_q[row_q] <= sat32(38'(mulq(34'(rot_q[rb0]), 34'(pj_q[0])))
				+ 38'(mulq(34'(rot_q[rb1]), 34'(pj_q[1])))
				+ 38'(mulq(34'(rot_q[rb2]), 34'(pj_q[2]))) + 38'(org_q[row_q]));
		if (state_q == ST_COL_MUL) begin
			// Lever arm from joint origin to end origin, then cross products.
			logic signed [33:0] w0, w1, w2, d0, d1, d2;
			w0 = 34'($signed(mem_rd[191:160]));
			w1 = 34'($signed(mem_rd[159:128]));
			w2 = 34'($signed(mem_rd[127:96]));
			d0 = 34'(org_q[0]) - 34'($signed(mem_rd[95:64]));
			d1 = 34'(org_q[1]) - 34'($signed(mem_rd[63:32]));
			d2 = 34'(org_q[2]) - 34'($signed(mem_rd[31:0]));
			lx_s1[0] <= mulq(w1, d2); lx_s1[1] <= mulq(w2, d1);
			lx_s1[2] <= mulq(w2, d0); lx_s1[3] <= mulq(w0, d2);
			lx_s1[4] <= mulq(w0, d1); lx_s1[5] <= mulq(w1, d0);
			ax_s1[0] <= w0[31:0]; ax_s1[1] <= w1[31:0]; ax_s1[2] <= w2[31:0];
		end
		if (state_q == ST_COL_OUT && (!out_valid || out_ready)) begin
			column_index <= 4'(col_q);
			lin_x <= sat32(38'(lx_s1[0]) - 38'(lx_s1[1]));
			lin_y <= sat32(38'(lx_s1[2]) - 38'(lx_s1[3]));
			lin_z <= sat32(38'(lx_s1[4]) - 38'(lx_s1[5]));
			ang_x <= ax_s1[0]; ang_y <= ax_s1[1]; ang_z <= ax_s1[2];
			last_column <= (col_q == k_q);
		end
	end

	// Drop no item: input is taken only while idle.
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_CORDIC) else $error("accept left idle");
	// Never emit a column while a joint is still being chained.
	a_out_cols: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_COL_OUT) else $error("stray column");
	// Count stays in range.
	a_k_rng: assert property (@(posedge clk) disable iff (!arst_n)
		32'(k_q) < MAX_JOINTS) else $error("joint count out of range");

endmodule
